// ----- sv/oavu_pkg.sv -----
// ----------------------------------------------------------------------------
// oavu_pkg
// Shared types, widths and sine/cosine/secant tables for the octant aim and
// velocity unit.
// ----------------------------------------------------------------------------
package oavu_pkg;

  // field widths
  localparam int unsigned COORD_W = 16;
  localparam int unsigned ANG_W   = 6;
  localparam int unsigned FLAG_W  = 3;
  localparam int unsigned VEL_W   = 24;
  localparam int unsigned DIST_W  = 17;

  // angle arithmetic: minor * 64 over major
  localparam int unsigned ANG_SHIFT  = 6;
  localparam int unsigned DIV_NUM_W  = COORD_W + ANG_SHIFT;
  localparam int unsigned QUO_LOW_W  = 8;
  localparam logic [QUO_LOW_W-1:0] ANG_LIMIT = 8'd64;
  localparam logic [ANG_W-1:0]     ANG_CLAMP = 6'd63;

  // pipeline layout
  localparam int unsigned DIV_STEPS_DEF = 4;
  localparam int unsigned FOLD_STAGES   = 2;
  localparam int unsigned RES_STAGES    = 4;

  // direction flag bit positions
  localparam int unsigned FLAG_MIR_X = 0;
  localparam int unsigned FLAG_MIR_Y = 1;
  localparam int unsigned FLAG_SWAP  = 2;

  localparam int unsigned ROM_DEPTH = 65;
  localparam int unsigned FACT_W    = 16;
  localparam int unsigned SEC_W     = 9;

  typedef struct packed {
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] base_x;
    logic signed [COORD_W-1:0] base_y;
    logic signed [COORD_W-1:0] base_speed;
  } oavu_in_t;

  typedef struct packed {
    logic [ANG_W-1:0]         octant_angle;
    logic [FLAG_W-1:0]        direction_flags;
    logic signed [VEL_W-1:0]  x_velocity;
    logic signed [VEL_W-1:0]  y_velocity;
    logic signed [DIST_W-1:0] axis_distance;
  } oavu_out_t;

  // values that ride along the divider
  typedef struct packed {
    logic [FLAG_W-1:0]         flags;
    logic signed [COORD_W-1:0] speed;
    logic signed [COORD_W-1:0] axis_dist;
    logic                      qneg;
    logic                      dzero;
  } oavu_side_t;

  // sine factors, entry 0 unused (zero angle passes the speed through)
  localparam logic [FACT_W-1:0] SIN_ROM [0:ROM_DEPTH-1] = '{
    16'd255,   16'd1024,  16'd2047,  16'd3069,  16'd4088,  16'd5104,  16'd6117,
    16'd7126,  16'd8129,  16'd9126,  16'd10117, 16'd11101, 16'd12078, 16'd13046,
    16'd14005, 16'd14955, 16'd15895, 16'd16825, 16'd17744, 16'd18651, 16'd19548,
    16'd20432, 16'd21304, 16'd22164, 16'd23011, 16'd23845, 16'd24666, 16'd25474,
    16'd26268, 16'd27049, 16'd27816, 16'd28569, 16'd29309, 16'd30034, 16'd30747,
    16'd31445, 16'd32130, 16'd32801, 16'd33459, 16'd34103, 16'd34734, 16'd35352,
    16'd35957, 16'd36549, 16'd37128, 16'd37695, 16'd38249, 16'd38791, 16'd39322,
    16'd39840, 16'd40347, 16'd40842, 16'd41327, 16'd41800, 16'd42262, 16'd42714,
    16'd43156, 16'd43587, 16'd44009, 16'd44420, 16'd44823, 16'd45216, 16'd45600,
    16'd45975, 16'd46341
  };

  // cosine factors
  localparam logic [FACT_W-1:0] COS_ROM [0:ROM_DEPTH-1] = '{
    16'd65535, 16'd65528, 16'd65504, 16'd65464, 16'd65408, 16'd65337, 16'd65250,
    16'd65147, 16'd65030, 16'd64897, 16'd64750, 16'd64589, 16'd64414, 16'd64224,
    16'd64022, 16'd63807, 16'd63579, 16'd63340, 16'd63088, 16'd62826, 16'd62553,
    16'd62270, 16'd61977, 16'd61674, 16'd61363, 16'd61044, 16'd60717, 16'd60383,
    16'd60041, 16'd59694, 16'd59340, 16'd58981, 16'd58617, 16'd58249, 16'd57876,
    16'd57499, 16'd57120, 16'd56737, 16'd56351, 16'd55964, 16'd55574, 16'd55183,
    16'd54791, 16'd54398, 16'd54004, 16'd53610, 16'd53216, 16'd52822, 16'd52429,
    16'd52036, 16'd51644, 16'd51253, 16'd50863, 16'd50475, 16'd50089, 16'd49704,
    16'd49321, 16'd48940, 16'd48561, 16'd48185, 16'd47811, 16'd47439, 16'd47071,
    16'd46704, 16'd46341
  };

  // secant factors, scaled by 256
  localparam logic [SEC_W-1:0] SEC_ROM [0:ROM_DEPTH-1] = '{
    9'd255, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd257, 9'd257, 9'd257, 9'd258,
    9'd259, 9'd259, 9'd260, 9'd261, 9'd262, 9'd262, 9'd263, 9'd264, 9'd265, 9'd267,
    9'd268, 9'd269, 9'd270, 9'd272, 9'd273, 9'd274, 9'd276, 9'd277, 9'd279, 9'd281,
    9'd282, 9'd284, 9'd286, 9'd288, 9'd289, 9'd291, 9'd293, 9'd295, 9'd297, 9'd299,
    9'd301, 9'd304, 9'd306, 9'd308, 9'd310, 9'd312, 9'd315, 9'd317, 9'd320, 9'd322,
    9'd324, 9'd327, 9'd329, 9'd332, 9'd334, 9'd337, 9'd340, 9'd342, 9'd345, 9'd348,
    9'd350, 9'd353, 9'd356, 9'd359, 9'd362
  };

endpackage

// ----- sv/oavu_pipe_ctl.sv -----
// ----------------------------------------------------------------------------
// oavu_pipe_ctl
// Valid bits and per-stage load enables; a stage loads when it is empty or
// when the stage after it moves, so bubbles are squeezed out under stall.
// ----------------------------------------------------------------------------
module oavu_pipe_ctl import oavu_pkg::*; #(
  parameter int unsigned NumStages = FOLD_STAGES + RES_STAGES + 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [NumStages-1:0] stage_en
);

  logic [NumStages-1:0] valid_r;
  logic [NumStages-1:0] valid_nxt;

  // load enables, from the output end back to the input
  always_comb begin
    stage_en[NumStages-1] = !valid_r[NumStages-1] || !out_stall;
    for (int i = NumStages - 2; i >= 0; i--) begin
      stage_en[i] = !valid_r[i] || stage_en[i+1];
    end
  end

  // valid bits follow the data
  always_comb begin
    valid_nxt = valid_r;
    if (stage_en[0]) begin
      valid_nxt[0] = in_valid;
    end
    for (int i = 1; i < NumStages; i++) begin
      if (stage_en[i]) begin
        valid_nxt[i] = valid_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_stall  = !stage_en[0];
  assign out_valid = valid_r[NumStages-1];

  // input backs up only when every stage holds a request
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&valid_r) && out_stall)
    else $error("input stalled with a free stage");

  // a free output side never blocks the input
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output side is free");

  // an accepted request lands in the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> valid_r[0])
    else $error("accepted request lost at entry");

endmodule

// ----- sv/oavu_fold.sv -----
// ----------------------------------------------------------------------------
// oavu_fold
// Two stages: wrapped differences with mirror rules, then axis swap, operand
// magnitudes for the divider and the absolute axis distance.
// ----------------------------------------------------------------------------
module oavu_fold import oavu_pkg::*; #(
  parameter int unsigned NumWidth = DIV_NUM_W
) (
  input  logic                clk,
  input  logic [1:0]          stage_en,
  input  oavu_in_t            in_data,
  output logic [NumWidth-1:0] div_num,
  output logic [COORD_W-1:0]  div_den,
  output oavu_side_t          side
);

  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  logic [COORD_W-1:0] ndx;
  logic [COORD_W-1:0] ndy;
  logic               mir_x;
  logic               mir_y;

  logic [COORD_W-1:0]        dxf_r, dxf_nxt;
  logic [COORD_W-1:0]        dyf_r, dyf_nxt;
  logic [COORD_W-1:0]        distx_r, distx_nxt;
  logic [COORD_W-1:0]        disty_r, disty_nxt;
  logic [1:0]                mir_r;
  logic signed [COORD_W-1:0] speed_r;

  logic               swap;
  logic [COORD_W-1:0] major;
  logic [COORD_W-1:0] minor;
  logic [COORD_W-1:0] major_mag;
  logic [COORD_W-1:0] minor_mag;

  logic [NumWidth-1:0] num_r, num_nxt;
  logic [COORD_W-1:0]  den_r, den_nxt;
  oavu_side_t          side_r, side_nxt;

  // stage 1: wrapped differences and mirror decisions
  always_comb begin
    dx    = in_data.target_x - in_data.base_x;
    dy    = in_data.target_y - in_data.base_y;
    ndx   = COORD_W'(0) - dx;
    ndy   = COORD_W'(0) - dy;
    mir_x = dx[COORD_W-1] ^ (in_data.target_x[COORD_W-1] ^ in_data.base_x[COORD_W-1]);
    mir_y = dy[COORD_W-1] & ~in_data.base_y[COORD_W-1];
    dxf_nxt = mir_x ? ndx : dx;
    dyf_nxt = mir_y ? ndy : dy;
    // base minus target, made positive except at the wrap edge
    distx_nxt = ndx[COORD_W-1] ? dx : ndx;
    disty_nxt = ndy[COORD_W-1] ? dy : ndy;
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      dxf_r   <= dxf_nxt;
      dyf_r   <= dyf_nxt;
      distx_r <= distx_nxt;
      disty_r <= disty_nxt;
      mir_r   <= {mir_y, mir_x};
      speed_r <= in_data.base_speed;
    end
  end

  // stage 2: swap, magnitudes and sign of the quotient
  always_comb begin
    swap      = $signed(dyf_r) >= $signed(dxf_r);
    major     = swap ? dyf_r : dxf_r;
    minor     = swap ? dxf_r : dyf_r;
    major_mag = major[COORD_W-1] ? COORD_W'(0) - major : major;
    minor_mag = minor[COORD_W-1] ? COORD_W'(0) - minor : minor;
    num_nxt   = '0;
    num_nxt[ANG_SHIFT +: COORD_W] = minor_mag;
    den_nxt   = major_mag;
    side_nxt.flags     = {swap, mir_r[1], mir_r[0]};
    side_nxt.speed     = speed_r;
    side_nxt.axis_dist = swap ? disty_r : distx_r;
    side_nxt.qneg      = minor[COORD_W-1] ^ major[COORD_W-1];
    side_nxt.dzero     = (major == '0);
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      num_r  <= num_nxt;
      den_r  <= den_nxt;
      side_r <= side_nxt;
    end
  end

  assign div_num = num_r;
  assign div_den = den_r;
  assign side    = side_r;

endmodule

// ----- sv/oavu_div.sv -----
// ----------------------------------------------------------------------------
// oavu_div
// Pipelined restoring divider on magnitudes; each stage retires a fixed
// number of quotient bits and keeps the low quotient byte only.
// ----------------------------------------------------------------------------
module oavu_div import oavu_pkg::*; #(
  parameter int unsigned Steps    = DIV_STEPS_DEF,
  parameter int unsigned Stages   = (DIV_NUM_W + DIV_STEPS_DEF - 1) / DIV_STEPS_DEF,
  parameter int unsigned NumWidth = Steps * Stages
) (
  input  logic                 clk,
  input  logic [Stages-1:0]    stage_en,
  input  logic [NumWidth-1:0]  div_num,
  input  logic [COORD_W-1:0]   div_den,
  input  oavu_side_t           side_in,
  output logic [QUO_LOW_W-1:0] quo,
  output oavu_side_t           side_out
);

  logic [COORD_W-1:0]   rem_r  [Stages];
  logic [NumWidth-1:0]  num_r  [Stages];
  logic [QUO_LOW_W-1:0] quo_r  [Stages];
  logic [COORD_W-1:0]   den_r  [Stages];
  oavu_side_t           side_r [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [COORD_W-1:0]   rem_in;
    logic [NumWidth-1:0]  num_in;
    logic [QUO_LOW_W-1:0] quo_in;
    logic [COORD_W-1:0]   den_in;
    oavu_side_t           side_s;
    logic [COORD_W-1:0]   rem_nxt;
    logic [NumWidth-1:0]  num_nxt;
    logic [QUO_LOW_W-1:0] quo_nxt;
    logic [COORD_W:0]     trial;

    // stage source: divider input or previous stage
    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = div_num;
      assign quo_in = '0;
      assign den_in = div_den;
      assign side_s = side_in;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign num_in = num_r[s-1];
      assign quo_in = quo_r[s-1];
      assign den_in = den_r[s-1];
      assign side_s = side_r[s-1];
    end

    // shift-subtract steps, most significant dividend bit first
    always_comb begin
      rem_nxt = rem_in;
      num_nxt = num_in;
      quo_nxt = quo_in;
      trial   = '0;
      for (int k = 0; k < Steps; k++) begin
        trial   = {rem_nxt, num_nxt[NumWidth-1]};
        num_nxt = num_nxt << 1;
        if (trial >= {1'b0, den_in}) begin
          trial   = trial - {1'b0, den_in};
          quo_nxt = {quo_nxt[QUO_LOW_W-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[QUO_LOW_W-2:0], 1'b0};
        end
        rem_nxt = trial[COORD_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (stage_en[s]) begin
        rem_r[s]  <= rem_nxt;
        num_r[s]  <= num_nxt;
        quo_r[s]  <= quo_nxt;
        den_r[s]  <= den_in;
        side_r[s] <= side_s;
      end
    end
  end

  assign quo      = quo_r[Stages-1];
  assign side_out = side_r[Stages-1];

endmodule

// ----- sv/oavu_resolve.sv -----
// ----------------------------------------------------------------------------
// oavu_resolve
// Angle clamp, table lookup, speed and distance products, and the output
// register with axis routing and mirror negation.
// ----------------------------------------------------------------------------
module oavu_resolve import oavu_pkg::*; (
  input  logic                 clk,
  input  logic [3:0]           stage_en,
  input  logic [QUO_LOW_W-1:0] quo,
  input  oavu_side_t           side_in,
  output oavu_out_t            out_data
);

  localparam int unsigned PROD_W  = COORD_W + FACT_W + 1;
  localparam int unsigned PDIST_W = COORD_W + SEC_W + 1;

  logic [QUO_LOW_W-1:0] ang8;
  logic [ANG_W-1:0]     ang_nxt;
  logic [ANG_W-1:0]     ang1_r, ang2_r, ang3_r;
  oavu_side_t           side1_r, side2_r, side3_r;

  logic [FACT_W-1:0] sinf_r, cosf_r;
  logic [SEC_W-1:0]  secf_r;

  logic signed [PROD_W-1:0]  psin_nxt, pcos_nxt, psin_r, pcos_r;
  logic signed [PDIST_W-1:0] pdist_nxt, pdist_r;

  logic [COORD_W-1:0] w_sin, w_cos, wx, wy;
  oavu_out_t          out_r, out_nxt;

  // stage 1: signed quotient byte, clamp to the octant range
  always_comb begin
    ang8 = side_in.qneg ? QUO_LOW_W'(0) - quo : quo;
    if (side_in.dzero) begin
      ang_nxt = '0;
    end else if (ang8 >= ANG_LIMIT) begin
      ang_nxt = ANG_CLAMP;
    end else begin
      ang_nxt = ang8[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      ang1_r  <= ang_nxt;
      side1_r <= side_in;
    end
  end

  // stage 2: table lookup
  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      sinf_r  <= SIN_ROM[{1'b0, ang1_r}];
      cosf_r  <= COS_ROM[{1'b0, ang1_r}];
      secf_r  <= SEC_ROM[{1'b0, ang1_r}];
      ang2_r  <= ang1_r;
      side2_r <= side1_r;
    end
  end

  // stage 3: products
  always_comb begin
    psin_nxt  = $signed(side2_r.speed) * $signed({1'b0, sinf_r});
    pcos_nxt  = $signed(side2_r.speed) * $signed({1'b0, cosf_r});
    pdist_nxt = $signed(side2_r.axis_dist) * $signed({1'b0, secf_r});
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      psin_r  <= psin_nxt;
      pcos_r  <= pcos_nxt;
      pdist_r <= pdist_nxt;
      ang3_r  <= ang2_r;
      side3_r <= side2_r;
    end
  end

  // stage 4: zero angle bypass, axis routing, mirror negation
  always_comb begin
    if (ang3_r == '0) begin
      w_sin = '0;
      w_cos = side3_r.speed;
    end else begin
      w_sin = psin_r[2*COORD_W-1:COORD_W];
      w_cos = pcos_r[2*COORD_W-1:COORD_W];
    end
    wx = side3_r.flags[FLAG_SWAP] ? w_sin : w_cos;
    wy = side3_r.flags[FLAG_SWAP] ? w_cos : w_sin;
    if (side3_r.flags[FLAG_MIR_X]) begin
      wx = COORD_W'(0) - wx;
    end
    if (side3_r.flags[FLAG_MIR_Y]) begin
      wy = COORD_W'(0) - wy;
    end
    out_nxt.octant_angle    = ang3_r;
    out_nxt.direction_flags = side3_r.flags;
    out_nxt.x_velocity      = {wx, 8'h00};
    out_nxt.y_velocity      = {wy, 8'h00};
    out_nxt.axis_distance   = pdist_r[DIST_W+7:8];
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

// ----- sv/octant_aim_velocity_unit.sv -----
// ----------------------------------------------------------------------------
// octant_aim_velocity_unit
// Folds a target/base difference into an octant, divides out the angle and
// resolves a speed into x/y velocity and an axis distance.
//
//   port group   dir  handshake           payload
//   in_*         in   in_valid/in_stall   oavu_in_t  (points and speed)
//   out_*        out  out_valid/out_stall oavu_out_t (angle, flags, results)
//
// One request per cycle enters while in_stall is low and passes the fold,
// divider and resolve stages; each divider stage retires DivSteps quotient
// bits. Reset clears only the stage valid bits. A stalled output holds its
// result; upstream stages keep filling until every stage is full.
// ----------------------------------------------------------------------------
module octant_aim_velocity_unit import oavu_pkg::*; #(
  parameter int unsigned DivSteps = DIV_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  oavu_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output oavu_out_t out_data
);

  localparam int unsigned DivStages = (DIV_NUM_W + DivSteps - 1) / DivSteps;
  localparam int unsigned NumWidth  = DivStages * DivSteps;
  localparam int unsigned NumStages = FOLD_STAGES + DivStages + RES_STAGES;

  logic [NumStages-1:0] stage_en;
  logic [NumWidth-1:0]  div_num;
  logic [COORD_W-1:0]   div_den;
  oavu_side_t           fold_side;
  logic [QUO_LOW_W-1:0] quo;
  oavu_side_t           div_side;

  // stage valids and load enables
  oavu_pipe_ctl #(
    .NumStages (NumStages)
  ) u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stage_en  (stage_en)
  );

  // octant fold
  oavu_fold #(
    .NumWidth (NumWidth)
  ) u_fold (
    .clk      (clk),
    .stage_en (stage_en[FOLD_STAGES-1:0]),
    .in_data  (in_data),
    .div_num  (div_num),
    .div_den  (div_den),
    .side     (fold_side)
  );

  // angle divider
  oavu_div #(
    .Steps    (DivSteps),
    .Stages   (DivStages),
    .NumWidth (NumWidth)
  ) u_div (
    .clk      (clk),
    .stage_en (stage_en[FOLD_STAGES +: DivStages]),
    .div_num  (div_num),
    .div_den  (div_den),
    .side_in  (fold_side),
    .quo      (quo),
    .side_out (div_side)
  );

  // lookup, products and output register
  oavu_resolve u_resolve (
    .clk      (clk),
    .stage_en (stage_en[FOLD_STAGES + DivStages +: RES_STAGES]),
    .quo      (quo),
    .side_in  (div_side),
    .out_data (out_data)
  );

endmodule

// ----- tb/octant_aim_velocity_unit_checker.sv -----
// ----------------------------------------------------------------------------
// octant_aim_velocity_unit_checker
// Watches both channels of the octant aim and velocity unit. Each accepted
// request is folded, divided and scaled by an independent model. The result
// is queued and compared field by field with the next accepted result.
// ----------------------------------------------------------------------------
module octant_aim_velocity_unit_checker import oavu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  oavu_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  oavu_out_t out_data,
  output int        mismatches,
  output int        checked,
  output int        angles_hit
);

  oavu_out_t aim_expected_q[$];
  oavu_out_t want_res;
  bit [63:0] angle_seen;

  assign angles_hit = $countones(angle_seen);

  // octant fold, angle division and speed/distance scaling for one request
  function automatic oavu_out_t predict_aim(oavu_in_t req);
    logic signed [COORD_W-1:0] dx, dy, major, minor, axis_dist;
    logic [FLAG_W-1:0]         flags;
    logic [7:0]                ang;
    logic [FACT_W-1:0]         w_sin, w_cos, wx, wy;
    longint                    p_sin, p_cos;
    int                        quo, dprod;
    oavu_out_t                 res;
    flags = '0;

    // x mirrors when the difference sign disagrees with the operand signs
    dx = req.target_x - req.base_x;
    if (dx[COORD_W-1] != (req.target_x[COORD_W-1] ^ req.base_x[COORD_W-1])) begin
      flags[FLAG_MIR_X] = 1'b1;
      dx = -dx;
    end

    // y mirrors only for a negative difference off a non-negative base
    dy = req.target_y - req.base_y;
    if (dy[COORD_W-1] && !req.base_y[COORD_W-1]) begin
      flags[FLAG_MIR_Y] = 1'b1;
      dy = -dy;
    end

    if (dy >= dx) begin
      flags[FLAG_SWAP] = 1'b1;
      major = dy;
      minor = dx;
    end else begin
      major = dx;
      minor = dy;
    end

    // truncating divide, low byte kept, clamped into the octant
    quo = (major == 0) ? 0 : (int'(minor) * 64) / int'(major);
    ang = quo[7:0];
    if (ang >= 8'd64) ang = 8'd63;

    // zero angle passes the speed straight through as the cosine word
    if (ang == 8'd0) begin
      w_sin = '0;
      w_cos = req.base_speed;
    end else begin
      p_sin = longint'(req.base_speed) * longint'(SIN_ROM[ang[ANG_W:0]]);
      p_cos = longint'(req.base_speed) * longint'(COS_ROM[ang[ANG_W:0]]);
      w_sin = p_sin[31:16];
      w_cos = p_cos[31:16];
    end
    if (flags[FLAG_SWAP]) begin
      wx = w_sin;
      wy = w_cos;
    end else begin
      wx = w_cos;
      wy = w_sin;
    end
    if (flags[FLAG_MIR_Y]) wy = -wy;
    if (flags[FLAG_MIR_X]) wx = -wx;

    // distance along the major axis, wrap edge left negative
    axis_dist = flags[FLAG_SWAP] ? req.base_y - req.target_y : req.base_x - req.target_x;
    if (axis_dist < 0) axis_dist = -axis_dist;
    dprod = int'(axis_dist) * int'(SEC_ROM[ang[ANG_W:0]]);
    dprod = dprod >>> 8;

    res.octant_angle    = ang[ANG_W-1:0];
    res.direction_flags = flags;
    res.x_velocity      = {wx, 8'h00};
    res.y_velocity      = {wy, 8'h00};
    res.axis_distance   = dprod[DIST_W-1:0];
    return res;
  endfunction

  task automatic flag_field(string field, longint want, longint got);
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    mismatches++;
  endtask

  // queue on request acceptance, compare on result acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      mismatches = 0;
      checked <= 0;
    end else begin
      if (in_valid && !in_stall) aim_expected_q.push_back(predict_aim(in_data));
      if (out_valid && !out_stall) begin
        if (aim_expected_q.size() == 0) begin
          $display("%0t: result with no request pending: expected none, actual %h",
                   $time, out_data);
          mismatches++;
        end else begin
          want_res = aim_expected_q.pop_front();
          if (out_data.octant_angle !== want_res.octant_angle)
            flag_field("octant_angle", want_res.octant_angle, out_data.octant_angle);
          if (out_data.direction_flags !== want_res.direction_flags)
            flag_field("direction_flags", want_res.direction_flags,
                       out_data.direction_flags);
          if (out_data.x_velocity !== want_res.x_velocity)
            flag_field("x_velocity", want_res.x_velocity, out_data.x_velocity);
          if (out_data.y_velocity !== want_res.y_velocity)
            flag_field("y_velocity", want_res.y_velocity, out_data.y_velocity);
          if (out_data.axis_distance !== want_res.axis_distance)
            flag_field("axis_distance", want_res.axis_distance, out_data.axis_distance);
          angle_seen[want_res.octant_angle] = 1'b1;
          checked <= checked + 1;
        end
      end
    end
  end

endmodule

// ----- tb/octant_aim_velocity_unit_test.sv -----
// ----------------------------------------------------------------------------
// octant_aim_velocity_unit_test
// Drives directed corner requests and then random point/speed requests into
// the octant aim and velocity unit, with random idling on both channels and
// one long output hold-off. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module octant_aim_velocity_unit_test;
  import oavu_pkg::*;

  localparam int RandReqs   = 1526;
  localparam int CalmReqs   = 200;
  localparam int HoldCycles = 120;
  localparam int HoldAfter  = 400;
  localparam logic [15:0] CORNERS [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF};

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  oavu_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  oavu_out_t out_data;

  int mismatches;
  int checked;
  int angles_hit;
  int sent = 0;
  int n_directed = 0;
  int send_idle_pct = 20;
  int recv_stall_pct = 20;
  bit calm = 1'b0;

  always #5 clk = ~clk;

  octant_aim_velocity_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  octant_aim_velocity_unit_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .checked    (checked),
    .angles_hit (angles_hit)
  );

  function automatic oavu_in_t mk_req(logic [15:0] tx, logic [15:0] ty, logic [15:0] bx,
                                      logic [15:0] by, logic [15:0] spd);
    oavu_in_t r;
    r.target_x   = tx;
    r.target_y   = ty;
    r.base_x     = bx;
    r.base_y     = by;
    r.base_speed = spd;
    return r;
  endfunction

  // mix of full-range, nearby, corner and small-coordinate requests
  function automatic oavu_in_t random_req();
    oavu_in_t r;
    r.target_x   = COORD_W'($urandom);
    r.target_y   = COORD_W'($urandom);
    r.base_x     = COORD_W'($urandom);
    r.base_y     = COORD_W'($urandom);
    r.base_speed = COORD_W'($urandom);
    case ($urandom_range(0, 3))
      1: begin
        r.target_x = COORD_W'(r.base_x + $urandom_range(0, 511) - 256);
        r.target_y = COORD_W'(r.base_y + $urandom_range(0, 511) - 256);
      end
      2: begin
        if ($urandom_range(0, 1)) r.target_x = CORNERS[$urandom_range(0, 4)];
        if ($urandom_range(0, 1)) r.target_y = CORNERS[$urandom_range(0, 4)];
        if ($urandom_range(0, 1)) r.base_x = CORNERS[$urandom_range(0, 4)];
        if ($urandom_range(0, 1)) r.base_y = CORNERS[$urandom_range(0, 4)];
        if ($urandom_range(0, 1)) r.base_speed = CORNERS[$urandom_range(0, 4)];
      end
      3: begin
        r.target_x = COORD_W'($urandom_range(0, 127) - 64);
        r.target_y = COORD_W'($urandom_range(0, 127) - 64);
        r.base_x   = COORD_W'($urandom_range(0, 127) - 64);
        r.base_y   = COORD_W'($urandom_range(0, 127) - 64);
      end
      default: ;
    endcase
    return r;
  endfunction

  // offer one request, after an optional idle burst, until it is taken
  task automatic send_req(oavu_in_t r);
    if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_directed(oavu_in_t r);
    send_req(r);
    n_directed++;
  endtask

  // request side
  initial begin : stimulus
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all zero: major axis zero
    send_directed(mk_req(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    // zero angle passes the speed through
    send_directed(mk_req(16'd100, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF));
    send_directed(mk_req(16'd100, 16'h0000, 16'h0000, 16'h0000, 16'h8000));
    // equal axes divide to 64 and clamp
    send_directed(mk_req(16'd100, 16'd100, 16'h0000, 16'h0000, 16'h8000));
    send_directed(mk_req(16'd100, 16'd50, 16'h0000, 16'h0000, 16'h7FFF));
    send_directed(mk_req(16'd100, 16'd63, 16'h0000, 16'h0000, 16'hFFFF));
    // negative x difference across a sign change is kept unmirrored
    send_directed(mk_req(-16'sd100, 16'd50, 16'h0000, 16'h0000, 16'd1234));
    // negative x difference with same signs mirrors
    send_directed(mk_req(-16'sd100, 16'd30, -16'sd50, 16'h0000, -16'sd999));
    // y mirrors off a non-negative base
    send_directed(mk_req(16'd20, -16'sd80, 16'h0000, 16'h0000, 16'd3000));
    // negative y difference off a negative base stays negative
    send_directed(mk_req(16'd100, -16'sd90, 16'h0000, -16'sd10, 16'd3000));
    // x difference wraps to minus one
    send_directed(mk_req(16'h7FFF, 16'd5, 16'h8000, 16'h0000, 16'd500));
    // x difference at the wrap edge
    send_directed(mk_req(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF));
    send_directed(mk_req(16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h7FFF));
    // both differences at the wrap edge, negative distance
    send_directed(mk_req(16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h8000));
    // negative major axis
    send_directed(mk_req(-16'sd100, -16'sd200, 16'h0000, -16'sd10, 16'd7777));
    // negative quotient whose low byte lands inside the octant
    send_directed(mk_req(16'd64, -16'sd251, 16'h0000, -16'sd1, 16'd20000));
    // negative quotient that clamps
    send_directed(mk_req(16'd100, -16'sd20, 16'h0000, -16'sd10, 16'd20000));
    // zero major with a nonzero minor
    send_directed(mk_req(16'd5, -16'sd50, 16'd5, -16'sd5, 16'd321));
    // swap with both axes mirrored
    send_directed(mk_req(-16'sd300, -16'sd400, -16'sd100, 16'd100, -16'sd4000));
    // uniform extremes
    send_directed(mk_req(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_directed(mk_req(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_directed(mk_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_directed(mk_req(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000));

    for (int i = 0; i < RandReqs; i++) begin
      if (i % 128 == 0) begin
        send_idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        recv_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      end
      if (i == RandReqs - CalmReqs) calm = 1'b1;
      send_req(random_req());
    end
    in_valid <= 1'b0;

    // drain, then allow for the pipeline depth
    @(posedge clk);
    while (checked < sent) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("sent %0d requests (%0d directed), checked %0d results, %0d of 64 angles seen",
             sent, n_directed, checked, angles_hit);
    $display("random idling on both sides plus a %0d-cycle output hold-off under load",
             HoldCycles);
    if (mismatches == 0 && checked == sent) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // result side: random stall bursts and one long hold-off
  initial begin : receiver
    bit held_long = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && !held_long && sent >= HoldAfter) begin
        held_long = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rst_n && !calm && $urandom_range(0, 99) < recv_stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // run limit
  initial begin : watchdog
    #2000000;
    $display("timeout with %0d of %0d results checked", checked, sent);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
sv/oavu_pkg.sv
sv/oavu_pipe_ctl.sv
sv/oavu_fold.sv
sv/oavu_div.sv
sv/oavu_resolve.sv
sv/octant_aim_velocity_unit.sv
tb/octant_aim_velocity_unit_checker.sv
tb/octant_aim_velocity_unit_test.sv
